[hw/rtl/adf_pkg.sv]
// ----------------------------------------------------------------------------
// Affine displacement field package
// Register map, reset values and fixed datapath widths shared by the
// affine displacement field unit and its testbench.
// ----------------------------------------------------------------------------
package adf_pkg;

  // Configuration port geometry: registers sit on 8-byte strides.
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_VOXEL_SIZE  = 3'd0;
  localparam logic [2:0] REG_ORIGIN      = 3'd1;
  localparam logic [2:0] REG_ROW_X       = 3'd2;
  localparam logic [2:0] REG_ROW_Y       = 3'd3;
  localparam logic [2:0] REG_ROW_Z       = 3'd4;
  localparam logic [2:0] REG_TRANSLATION = 3'd5;
  localparam logic [2:0] REG_ENABLE      = 3'd6;

  // Reset values: voxel size x=y=0x0101, z=0; identity matrix; all else zero.
  localparam logic [47:0] VoxelSizeRst = 48'd16843009;
  localparam logic [59:0] OriginRst    = 60'd0;
  localparam logic [47:0] RowXRst      = 48'd4096;
  localparam logic [47:0] RowYRst      = 48'd268435456;
  localparam logic [47:0] RowZRst      = 48'd17592186044416;
  localparam logic [59:0] TransRst     = 60'd0;
  localparam logic [1:0]  EnableRst    = 2'd0;

  // Enable flag bit positions.
  localparam int unsigned EnXformBit = 0;
  localparam int unsigned EnDeformBit = 1;

  // Default grid dimension limit.
  localparam int unsigned MaxDimDefault = 1024;

  // Field widths of one transaction.
  localparam int unsigned IdxW  = 10;
  localparam int unsigned DispW = 24;

endpackage

[hw/rtl/affine_displacement_field_unit.sv]
// ----------------------------------------------------------------------------
// Affine displacement field unit
// Throughput: one voxel per cycle while the output is not stalled, set by the five-stage multiply-add pipeline.
// Reset: rst_ni clears all pipeline valid bits and loads the identity
// transform with zero origin and translation and both enables off.
// ----------------------------------------------------------------------------
module affine_displacement_field_unit #(
  parameter int unsigned MaxDim = adf_pkg::MaxDimDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [adf_pkg::AddrW-1:0] paddr,
  input  logic [adf_pkg::DataW-1:0] pwdata,
  output logic [adf_pkg::DataW-1:0] prdata,
  output logic                      pready,
  // Voxel input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // voxel_x[9:0], voxel_y[19:10], voxel_z[29:20], deform_x[53:30],
  // deform_y[77:54], deform_z[101:78], zero fill [103:102]
  input  logic [103:0]              s_axis_tdata,
  // Displacement output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // disp_x[23:0], disp_y[47:24], disp_z[71:48]
  output logic [71:0]               m_axis_tdata,
  // saturated[0]
  output logic                      m_axis_tuser
);
  import adf_pkg::*;

  localparam int unsigned IdxLimit = (MaxDim > 1024) ? 1023 : (MaxDim - 1);
  localparam logic [IdxW-1:0] IdxMax = IdxLimit[IdxW-1:0];

  // Configuration registers.
  logic [47:0] vsize_q;
  logic [59:0] origin_q;
  logic [47:0] row_x_q, row_y_q, row_z_q;
  logic [59:0] trans_q;
  logic [1:0]  enable_q;

  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[5:3];

  // Register writes; bits above a register's width are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsize_q  <= VoxelSizeRst;
      origin_q <= OriginRst;
      row_x_q  <= RowXRst;
      row_y_q  <= RowYRst;
      row_z_q  <= RowZRst;
      trans_q  <= TransRst;
      enable_q <= EnableRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_VOXEL_SIZE:  vsize_q  <= pwdata[47:0];
        REG_ORIGIN:      origin_q <= pwdata[59:0];
        REG_ROW_X:       row_x_q  <= pwdata[47:0];
        REG_ROW_Y:       row_y_q  <= pwdata[47:0];
        REG_ROW_Z:       row_z_q  <= pwdata[47:0];
        REG_TRANSLATION: trans_q  <= pwdata[59:0];
        REG_ENABLE:      enable_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      REG_VOXEL_SIZE:  prdata = {16'd0, vsize_q};
      REG_ORIGIN:      prdata = {4'd0, origin_q};
      REG_ROW_X:       prdata = {16'd0, row_x_q};
      REG_ROW_Y:       prdata = {16'd0, row_y_q};
      REG_ROW_Z:       prdata = {16'd0, row_z_q};
      REG_TRANSLATION: prdata = {4'd0, trans_q};
      REG_ENABLE:      prdata = {62'd0, enable_q};
      default:         prdata = '0;
    endcase
  end

  // Unpacked views of the configuration.
  logic               [15:0] vsize  [3];
  logic signed        [19:0] origin [3];
  logic signed        [19:0] trans  [3];
  logic signed        [15:0] coef   [3][3];
  logic [IdxW-1:0]           idx_in [3];
  logic signed [DispW-1:0]   dfm_in [3];
  logic                      do_xform, do_deform;

  assign do_xform  = enable_q[EnXformBit];
  assign do_deform = enable_q[EnDeformBit];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vsize[a]   = vsize_q[16*a +: 16];
      origin[a]  = origin_q[20*a +: 20];
      trans[a]   = trans_q[20*a +: 20];
      coef[0][a] = row_x_q[16*a +: 16];
      coef[1][a] = row_y_q[16*a +: 16];
      coef[2][a] = row_z_q[16*a +: 16];
      idx_in[a]  = s_axis_tdata[IdxW*a +: IdxW];
      dfm_in[a]  = s_axis_tdata[30 + DispW*a +: DispW];
    end
  end

  // Stage advance chain: a stage loads when it is empty or drains forward.
  logic v1_q, v2_q, v3_q, v4_q, out_vld_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = ~out_vld_q | m_axis_tready;
  assign en4 = ~v4_q | en5;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1) v1_q      <= s_axis_tvalid;
      if (en2) v2_q      <= v1_q;
      if (en3) v3_q      <= v2_q;
      if (en4) v4_q      <= v3_q;
      if (en5) out_vld_q <= v4_q;
    end
  end

  // Stage 1: physical position p and deformed position q.
  logic [IdxW-1:0]         idx_c  [3];
  logic [25:0]             scl    [3];
  logic signed [27:0]      p1_d   [3], p1_q [3];
  logic signed [28:0]      q1_d   [3], q1_q [3];
  logic signed [DispW-1:0] dfm1_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      idx_c[a] = (idx_in[a] > IdxMax) ? IdxMax : idx_in[a];
      scl[a]   = 26'(idx_c[a]) * 26'(vsize[a]);
      p1_d[a]  = signed'({2'b00, scl[a]}) - 28'(origin[a]);
      q1_d[a]  = 29'(p1_d[a]) + (do_deform ? 29'(dfm_in[a]) : 29'sd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int a = 0; a < 3; a++) begin
        p1_q[a]   <= p1_d[a];
        q1_q[a]   <= q1_d[a];
        dfm1_q[a] <= dfm_in[a];
      end
    end
  end

  // Stage 2: nine coefficient products and the translation offset t - p.
  logic signed [44:0]      prod2_q [3][3];
  logic signed [28:0]      ofs2_q  [3];
  logic signed [DispW-1:0] dfm2_q  [3];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod2_q[a][k] <= 45'(coef[a][k]) * 45'(q1_q[k]);
        end
        ofs2_q[a] <= 29'(trans[a]) - 29'(p1_q[a]);
        dfm2_q[a] <= dfm1_q[a];
      end
    end
  end

  // Stage 3: sum of the three products of each row.
  logic signed [46:0]      sum3_q [3];
  logic signed [28:0]      ofs3_q [3];
  logic signed [DispW-1:0] dfm3_q [3];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int a = 0; a < 3; a++) begin
        sum3_q[a] <= 47'(prod2_q[a][0]) + 47'(prod2_q[a][1]) + 47'(prod2_q[a][2]);
        ofs3_q[a] <= ofs2_q[a];
        dfm3_q[a] <= dfm2_q[a];
      end
    end
  end

  // Stage 4: add the scaled offset and half an output LSB.
  logic signed [47:0]      acc4_q [3];
  logic signed [DispW-1:0] dfm4_q [3];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int a = 0; a < 3; a++) begin
        acc4_q[a] <= 48'(sum3_q[a]) + signed'({ {7{ofs3_q[a][28]}}, ofs3_q[a], 12'd0 })
                     + 48'sd2048;
        dfm4_q[a] <= dfm3_q[a];
      end
    end
  end

  // Stage 5: floor to Q.8, saturate, pass the deformation through, or output zero.
  logic signed [35:0]      rnd     [3];
  logic                    ovf     [3];
  logic signed [DispW-1:0] disp_d  [3];
  logic [DispW-1:0]        disp_q  [3];
  logic                    sat_d, sat_q;

  always_comb begin
    sat_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      rnd[a] = acc4_q[a][47:12];
      ovf[a] = (rnd[a][35:23] != {13{rnd[a][35]}});
      if (!do_xform) begin
        disp_d[a] = do_deform ? dfm4_q[a] : '0;
      end else if (ovf[a]) begin
        disp_d[a] = rnd[a][35] ? {1'b1, {(DispW-1){1'b0}}} : {1'b0, {(DispW-1){1'b1}}};
        sat_d     = 1'b1;
      end else begin
        disp_d[a] = rnd[a][DispW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      for (int a = 0; a < 3; a++) begin
        disp_q[a] <= disp_d[a];
      end
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {disp_q[2], disp_q[1], disp_q[0]};
  assign m_axis_tuser  = sat_q;

`ifndef SYNTH
  // Back pressure reaches the input only when every stage holds a voxel.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && out_vld_q))
    else $error("input stalled while the pipeline has a free stage");

  // A voxel leaving the last stage shows up at the output in the next cycle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5) |=> out_vld_q)
    else $error("voxel lost between the last stage and the output register");

  // The saturation flag only accompanies a clipped component.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && sat_q) |->
      (disp_q[0] == 24'h7FFFFF || disp_q[0] == 24'h800000 ||
       disp_q[1] == 24'h7FFFFF || disp_q[1] == 24'h800000 ||
       disp_q[2] == 24'h7FFFFF || disp_q[2] == 24'h800000))
    else $error("saturation flag set without a clipped component");
`endif

endmodule

[verif/affine_displacement_field_unit_tb.sv]
// ----------------------------------------------------------------------------
// Affine displacement field unit testbench
// Streams voxel transactions through the unit and checks every displacement
// against a typed value or fixed-point model of position, deformation and
// affine stages. A short table of directed voxels covers reset values,
// pass-through deformation, saturation at both rails and rounding ties. A
// random part then follows under several register settings. Both stream
// sides idle at random, and the output side holds off once for a long time.
// ----------------------------------------------------------------------------
module affine_displacement_field_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adf_pkg::*;

  localparam int unsigned NumRegs     = 7;
  localparam logic [2:0]  RegUnmapped = 3'd7;
  localparam int unsigned Latency     = 5;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned MaxPrinted  = 100;
  localparam longint      DispMax     = 64'sd8388607;
  localparam longint      DispMin     = -64'sd8388608;

  localparam logic [1:0] EnOff    = 2'b00;
  localparam logic [1:0] EnXform  = 2'(1 << EnXformBit);
  localparam logic [1:0] EnDeform = 2'(1 << EnDeformBit);
  localparam logic [1:0] EnBoth   = EnXform | EnDeform;

  // One voxel transaction, laid out exactly as the low 102 bits of the input tdata.
  typedef struct packed {
    logic [2:0][DispW-1:0] deform;
    logic [2:0][IdxW-1:0]  idx;
  } voxel_t;

  // One displacement transaction: tdata fields plus the tuser flag.
  typedef struct packed {
    logic                  sat;
    logic [2:0][DispW-1:0] disp;
  } disp_t;

  typedef enum logic [2:0] {
    PH_RESET, PH_DEFORM, PH_SAT_HI, PH_SAT_LO, PH_ROUND, PH_MIXED
  } dir_phase_e;

  typedef enum logic [1:0] {
    CFG_NEAR_IDENTITY, CFG_RANDOM, CFG_EXTREME
  } cfg_mode_e;

  typedef struct {
    dir_phase_e phase;
    voxel_t     vox;
    bit         typed;
    disp_t      want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // voxel_x, voxel_y, voxel_z, deform_x, deform_y, deform_z, zero fill
  logic [103:0]        s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // disp_x, disp_y, disp_z
  logic [71:0]         m_axis_tdata;
  // saturated
  logic                m_axis_tuser;

  logic [63:0] cfg_shadow [NumRegs];
  logic [63:0] staged_cfg [NumRegs];
  disp_t       expected_disp_q [$];
  stim_row_t   stim_rows [$];
  string       axis_name [3] = '{"x", "y", "z"};
  cfg_mode_e   mode_seq [4] = '{CFG_NEAR_IDENTITY, CFG_RANDOM, CFG_NEAR_IDENTITY, CFG_EXTREME};

  int unsigned fail_count = 0;
  int unsigned voxels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;

  affine_displacement_field_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] reg_mask(input logic [2:0] idx);
    int unsigned w;
    case (idx)
      REG_ORIGIN, REG_TRANSLATION: w = 60;
      REG_ENABLE: w = 2;
      default: w = 48;
    endcase
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic void load_reset_values(ref logic [63:0] regs [NumRegs]);
    regs[REG_VOXEL_SIZE]  = 64'(VoxelSizeRst);
    regs[REG_ORIGIN]      = 64'(OriginRst);
    regs[REG_ROW_X]       = 64'(RowXRst);
    regs[REG_ROW_Y]       = 64'(RowYRst);
    regs[REG_ROW_Z]       = 64'(RowZRst);
    regs[REG_TRANSLATION] = 64'(TransRst);
    regs[REG_ENABLE]      = 64'(EnableRst);
  endfunction

  // Fixed-point displacement of one voxel under the current register values.
  // Positions are Q.8, matrix products Q.20; only the final value is rounded.
  function automatic disp_t predict_displacement(input voxel_t v);
    longint pos [3];
    longint moved [3];
    longint acc;
    longint rounded;
    longint idx;
    disp_t  r;
    r = '0;
    for (int a = 0; a < 3; a++) begin
      idx = longint'(v.idx[a]);
      if (idx >= longint'(MaxDimDefault)) idx = longint'(MaxDimDefault) - 1;
      pos[a] = idx * longint'(cfg_shadow[REG_VOXEL_SIZE][16*a +: 16])
               - longint'($signed(cfg_shadow[REG_ORIGIN][20*a +: 20]));
      moved[a] = pos[a];
      if (cfg_shadow[REG_ENABLE][EnDeformBit]) moved[a] += longint'($signed(v.deform[a]));
    end
    for (int a = 0; a < 3; a++) begin
      if (cfg_shadow[REG_ENABLE][EnXformBit]) begin
        acc = longint'($signed(cfg_shadow[REG_TRANSLATION][20*a +: 20])) * 4096
              - pos[a] * 4096;
        for (int k = 0; k < 3; k++) begin
          acc += longint'($signed(cfg_shadow[REG_ROW_X + a][16*k +: 16])) * moved[k];
        end
        // Add half an LSB and floor, so ties go toward plus infinity.
        rounded = (acc + 2048) >>> 12;
        if (rounded > DispMax) begin
          rounded = DispMax;
          r.sat = 1'b1;
        end else if (rounded < DispMin) begin
          rounded = DispMin;
          r.sat = 1'b1;
        end
      end else begin
        rounded = moved[a] - pos[a];
      end
      r.disp[a] = rounded[DispW-1:0];
    end
    return r;
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) $display("[%0t] FAIL: %s", $time, msg);
  endtask

  // Compare one accepted displacement transaction with the oldest expectation.
  task automatic check_displacement(input disp_t got);
    disp_t want;
    results_seen++;
    if (expected_disp_q.size() == 0) begin
      report_failure($sformatf("unexpected displacement %h", got));
      return;
    end
    want = expected_disp_q.pop_front();
    for (int a = 0; a < 3; a++) begin
      if (got.disp[a] !== want.disp[a]) begin
        report_failure($sformatf("result %0d disp_%s: got %0d expected %0d", results_seen,
                                 axis_name[a], $signed(got.disp[a]), $signed(want.disp[a])));
      end
    end
    if (got.sat !== want.sat) begin
      report_failure($sformatf("result %0d saturated: got %b expected %b", results_seen,
                               got.sat, want.sat));
    end
  endtask

  // Inputs only change at rising edges, so values seen at the falling edge
  // are the ones the next rising edge accepts.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_displacement({m_axis_tuser, m_axis_tdata});
    end
  end

  // Output-side stall pattern, with one long hold-off on request.
  initial begin : output_stalls
    int unsigned hold_left;
    int unsigned span;
    int unsigned mode;
    hold_left = 0;
    span = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 80);
        end
        span--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    if (idx < NumRegs) cfg_shadow[idx] = value & reg_mask(idx);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all staged registers with junk above each register's width, then
  // poke the unmapped address, which must change nothing.
  task automatic program_registers();
    for (int i = 0; i < NumRegs; i++) begin
      write_register(3'(i), staged_cfg[i] | ({$urandom, $urandom} & ~reg_mask(3'(i))));
    end
    write_register(RegUnmapped, {$urandom, $urandom});
  endtask

  // Offer one voxel transaction, in bursts with random gaps between them.
  task automatic send_voxel(input voxel_t v, input disp_t want);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, v};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    burst_left--;
    expected_disp_q.push_back(want);
    voxels_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_disp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_row(input dir_phase_e ph, input int ix, input int iy, input int iz,
                                  input int dx, input int dy, input int dz, input bit typed,
                                  input int wx, input int wy, input int wz, input bit wsat);
    stim_row_t row;
    row.phase = ph;
    row.vox.idx = {10'(iz), 10'(iy), 10'(ix)};
    row.vox.deform = {24'(dz), 24'(dy), 24'(dx)};
    row.typed = typed;
    row.want.disp = {24'(wz), 24'(wy), 24'(wx)};
    row.want.sat = wsat;
    stim_rows.push_back(row);
  endfunction

  // Register settings of the directed phases, starting from reset values.
  task automatic stage_directed_config(input dir_phase_e ph);
    load_reset_values(staged_cfg);
    case (ph)
      PH_DEFORM: begin
        staged_cfg[REG_VOXEL_SIZE] = 64'({16'hFFFF, 16'hFFFF, 16'hFFFF});
        staged_cfg[REG_ORIGIN]     = 64'({20'h00000, 20'h80000, 20'h7FFFF});
        staged_cfg[REG_ENABLE]     = 64'(EnDeform);
      end
      PH_SAT_HI, PH_SAT_LO: begin
        staged_cfg[REG_VOXEL_SIZE] = 64'({16'h0100, 16'h0100, 16'hFFFF});
        staged_cfg[REG_ROW_X]      = (ph == PH_SAT_HI) ? 64'h7FFF : 64'h8000;
        staged_cfg[REG_ENABLE]     = 64'(EnXform);
      end
      PH_ROUND: begin
        // Half-unit x coefficient on a 1/256 mm voxel makes exact ties.
        staged_cfg[REG_VOXEL_SIZE] = 64'({16'h0100, 16'h0100, 16'h0001});
        staged_cfg[REG_ROW_X]      = 64'h0800;
        staged_cfg[REG_ENABLE]     = 64'(EnXform);
      end
      PH_MIXED: begin
        staged_cfg[REG_VOXEL_SIZE]  = 64'({16'hFFFF, 16'h1234, 16'h0040});
        staged_cfg[REG_ORIGIN]      = 64'({20'h00001, 20'h7FFFF, 20'h80000});
        staged_cfg[REG_ROW_X]       = 64'({16'h1100, 16'hFFF0, 16'h0010});
        staged_cfg[REG_ROW_Y]       = 64'({16'h0123, 16'h0F00, 16'h8000});
        staged_cfg[REG_ROW_Z]       = 64'({16'h1000, 16'h7FFF, 16'h0000});
        staged_cfg[REG_TRANSLATION] = 64'({20'h12345, 20'h80000, 20'h7FFFF});
        staged_cfg[REG_ENABLE]      = 64'(EnBoth);
      end
      default: staged_cfg[REG_ENABLE] = 64'(EnOff);
    endcase
  endtask

  task automatic stage_random_config(input cfg_mode_e mode, input bit all_zero,
                                     input logic [1:0] en);
    int coeff;
    for (int i = 0; i < NumRegs; i++) staged_cfg[i] = '0;
    case (mode)
      CFG_NEAR_IDENTITY: begin
        for (int a = 0; a < 3; a++) begin
          staged_cfg[REG_VOXEL_SIZE][16*a +: 16] = 16'($urandom_range(1, 16'h0300));
          staged_cfg[REG_ORIGIN][20*a +: 20] = 20'($urandom);
          staged_cfg[REG_TRANSLATION][20*a +: 20] = 20'($urandom);
          for (int k = 0; k < 3; k++) begin
            coeff = ((a == k) ? 4096 : 0) + int'($urandom_range(0, 800)) - 400;
            staged_cfg[REG_ROW_X + a][16*k +: 16] = coeff[15:0];
          end
        end
      end
      CFG_RANDOM: begin
        for (int i = 0; i < NumRegs; i++) staged_cfg[i] = {$urandom, $urandom};
      end
      default: begin
        for (int i = 0; i < NumRegs; i++) staged_cfg[i] = all_zero ? '0 : '1;
      end
    endcase
    staged_cfg[REG_ENABLE] = 64'(en);
  endtask

  function automatic voxel_t random_voxel();
    voxel_t v;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(0, 7))
        0: v.idx[a] = '0;
        1: v.idx[a] = '1;
        default: v.idx[a] = 10'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: v.deform[a] = 24'(int'($urandom_range(0, 2048)) - 1024);
        1: v.deform[a] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        default: v.deform[a] = 24'($urandom);
      endcase
    end
    return v;
  endfunction

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin : stimulus
    dir_phase_e  cur_phase;
    voxel_t      v;
    int unsigned n;
    load_reset_values(cfg_shadow);

    // Directed voxels. Typed results follow directly from the settings.
    add_row(PH_RESET, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(PH_RESET, 1023, 1023, 1023, 8388607, 8388607, 8388607, 1, 0, 0, 0, 0);
    add_row(PH_RESET, 1023, 0, 512, -8388608, -8388608, -8388608, 1, 0, 0, 0, 0);
    add_row(PH_DEFORM, 0, 0, 0, 8388607, -8388608, 0, 1, 8388607, -8388608, 0, 0);
    add_row(PH_DEFORM, 1023, 1023, 1023, -8388608, 8388607, -1,
            1, -8388608, 8388607, -1, 0);
    add_row(PH_DEFORM, 5, 6, 7, 1, -1, 'h123456, 1, 1, -1, 'h123456, 0);
    add_row(PH_SAT_HI, 1023, 0, 0, 8388607, 8388607, 8388607, 1, 8388607, 0, 0, 1);
    add_row(PH_SAT_HI, 0, 0, 0, -8388608, 0, 0, 1, 0, 0, 0, 0);
    add_row(PH_SAT_LO, 1023, 0, 0, 0, 0, 0, 1, -8388608, 0, 0, 1);
    add_row(PH_SAT_LO, 1023, 1023, 1023, 0, 0, 0, 1, -8388608, 0, 0, 1);
    add_row(PH_ROUND, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(PH_ROUND, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(PH_ROUND, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(PH_ROUND, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(PH_MIXED, 0, 0, 0, 8388607, 8388607, 8388607, 0, 0, 0, 0, 0);
    add_row(PH_MIXED, 1023, 1023, 1023, -8388608, -8388608, -8388608, 0, 0, 0, 0, 0);
    add_row(PH_MIXED, 1, 512, 1022, 256, -256, 1, 0, 0, 0, 0, 0);
    add_row(PH_MIXED, 700, 3, 1023, -1, 0, 8388607, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    cur_phase = PH_RESET;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].phase != cur_phase) begin
        wait_idle();
        cur_phase = stim_rows[i].phase;
        stage_directed_config(cur_phase);
        program_registers();
      end
      send_voxel(stim_rows[i].vox, stim_rows[i].typed ? stim_rows[i].want
                                                       : predict_displacement(stim_rows[i].vox));
    end

    // Random voxels under a sequence of register settings.
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      stage_random_config(mode_seq[ph % 4], (ph / 4) % 2 == 1, 2'((ph / 2) % 4));
      program_registers();
      n = $urandom_range(120, 180);
      for (int i = 0; i < n; i++) begin
        // Hold the output off while input transactions keep coming.
        if (ph == 3 && i == 5) long_hold_req = 1'b1;
        v = random_voxel();
        send_voxel(v, predict_displacement(v));
      end
    end

    wait_idle();
    repeat (4 * Latency) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/adf_pkg.sv
hw/rtl/affine_displacement_field_unit.sv
verif/affine_displacement_field_unit_tb.sv
